// ----- sv/gisc_pkg.sv -----
// shared types and constants for the grid influence stamp and check unit
// no dependencies
package gisc_pkg;

    localparam int COL_W       = 8;
    localparam int RAD_W       = 4;
    localparam int AMT_W       = 12;
    localparam int FP_W        = 4;
    localparam int TOL_W       = 15;
    localparam int CELL_W      = 16;
    localparam int EXT_W       = 9;
    localparam int CFG_IDX_W   = 1;
    localparam int COORD_W     = 12;
    localparam int DEF_GRID_COLS = 256;
    localparam int DEF_GRID_ROWS = 256;

    localparam logic signed [CELL_W-1:0] CELL_MAX = 16'sh7FFF;
    localparam logic signed [CELL_W-1:0] CELL_MIN = 16'sh8000;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_STAMP = 2'd1,
        OP_READ  = 2'd2,
        OP_CHECK = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COLS = 1'b0,
        CFG_ROWS = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        S_BOOT,
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic boot;
        logic load;
        logic step;
    } ctrl_cmd_t;

    typedef struct packed {
        logic empty;
        logic last;
    } dp_status_t;

endpackage

// ----- sv/gisc_ram.sv -----
// generic single write port ram with registered read
// no dependencies
module gisc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/gisc_ctrl.sv -----
// sequencing state machine: boot clear sweep, item load, cell walk, result strobe
// depends on gisc_pkg
module gisc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  gisc_pkg::dp_status_t status,
    output gisc_pkg::ctrl_cmd_t  cmd,
    output logic                 busy,
    output logic                 done
);

    import gisc_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   silent_reg;
    logic   silent_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_BOOT;
            silent_reg <= 1'b1;
        end
        else
        begin
            state_reg  <= state_next;
            silent_reg <= silent_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        silent_next = silent_reg;
        cmd         = '0;
        busy        = 1'b1;
        done        = 1'b0;
        case (state_reg)
            S_BOOT:
            begin
                cmd.boot   = 1'b1;
                cmd.load   = 1'b1;
                state_next = S_SCAN;
            end
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load    = 1'b1;
                    silent_next = 1'b0;
                    state_next  = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (status.empty)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    cmd.step = 1'b1;
                    if (status.last)
                    begin
                        state_next = S_DRAIN;
                    end
                end
            end
            S_DRAIN:
            begin
                state_next = silent_reg ? S_IDLE : S_DONE;
            end
            S_DONE:
            begin
                done       = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/gisc_dp.sv -----
// datapath: map extent registers, cell walker, read-modify-write stage, result flags
// depends on gisc_pkg and gisc_ram
module gisc_dp #(
    parameter int GRID_COLS = 256,
    parameter int GRID_ROWS = 256
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  gisc_pkg::ctrl_cmd_t                   cmd,
    output gisc_pkg::dp_status_t                  status,
    input  logic [1:0]                            op,
    input  logic [gisc_pkg::COL_W-1:0]            col,
    input  logic [gisc_pkg::COL_W-1:0]            row,
    input  logic [gisc_pkg::RAD_W-1:0]            inner_radius,
    input  logic [gisc_pkg::RAD_W-1:0]            ring_thickness,
    input  logic signed [gisc_pkg::AMT_W-1:0]     inner_amount,
    input  logic signed [gisc_pkg::AMT_W-1:0]     ring_amount,
    input  logic [gisc_pkg::FP_W-1:0]             footprint_cols,
    input  logic [gisc_pkg::FP_W-1:0]             footprint_rows,
    input  logic [gisc_pkg::TOL_W-1:0]            tolerance,
    input  logic                                  cfg_valid,
    input  logic [gisc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [gisc_pkg::EXT_W-1:0]            cfg_data,
    output logic signed [gisc_pkg::CELL_W-1:0]    cell_threat,
    output logic                                  allowed,
    output logic                                  stamp_applied,
    output logic                                  saturated
);

    import gisc_pkg::*;

    localparam int CW    = $clog2(GRID_COLS);
    localparam int RW    = $clog2(GRID_ROWS);
    localparam int AW    = CW + RW;
    localparam int DEPTH = 1 << AW;

    localparam coord_t GC_C = coord_t'(GRID_COLS);
    localparam coord_t GR_C = coord_t'(GRID_ROWS);

    // map extent
    logic [EXT_W-1:0] cols_reg;
    logic [EXT_W-1:0] rows_reg;
    coord_t           cols_ext;
    coord_t           rows_ext;
    coord_t           cols_eff;
    coord_t           rows_eff;

    // item registers
    op_t                      op_reg;
    coord_t                   i_lo_reg, i_hi_reg, j_hi_reg;
    coord_t                   ii_lo_reg, ii_hi_reg, ji_lo_reg, ji_hi_reg;
    coord_t                   i_reg, j_reg;
    logic                     empty_reg;
    logic signed [AMT_W-1:0]  ia_reg, ra_reg;
    logic [TOL_W-1:0]         tol_reg;

    // access stage
    logic                     p_valid_reg;
    logic [AW-1:0]            p_addr_reg;
    logic signed [AMT_W-1:0]  p_amt_reg;

    // results
    logic signed [CELL_W-1:0] cell_reg;
    logic                     allowed_reg;
    logic                     applied_reg;
    logic                     sat_reg;

    // load decode
    op_t    op_in;
    coord_t col_c, row_c, rad, inr_c, fc_c, fr_c;
    logic   fit;
    coord_t i_lo_in, i_hi_in, j_lo_in, j_hi_in;
    logic   empty_in;

    // walker
    logic          in_grid;
    logic          acc;
    logic          inner;
    logic [AW-1:0] addr0;

    // ram and rmw
    logic [CELL_W-1:0]        rdata;
    logic signed [CELL_W:0]   sum;
    logic                     sum_sat;
    logic signed [CELL_W-1:0] sum_clamp;
    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic [CELL_W-1:0]        ram_wdata;

    assign cols_ext = coord_t'({{(COORD_W-EXT_W){1'b0}}, cols_reg});
    assign rows_ext = coord_t'({{(COORD_W-EXT_W){1'b0}}, rows_reg});
    assign cols_eff = (cols_ext < GC_C) ? cols_ext : GC_C;
    assign rows_eff = (rows_ext < GR_C) ? rows_ext : GR_C;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= EXT_W'(DEF_GRID_COLS);
            rows_reg <= EXT_W'(DEF_GRID_ROWS);
        end
        else if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_COLS: cols_reg <= cfg_data;
                CFG_ROWS: rows_reg <= cfg_data;
                default:  cols_reg <= cols_reg;
            endcase
        end
    end

    always_comb
    begin
        op_in = cmd.boot ? OP_CLEAR : op_t'(op);
        col_c = coord_t'({{(COORD_W-COL_W){1'b0}}, col});
        row_c = coord_t'({{(COORD_W-COL_W){1'b0}}, row});
        inr_c = coord_t'({{(COORD_W-RAD_W){1'b0}}, inner_radius});
        rad   = inr_c + coord_t'({{(COORD_W-RAD_W){1'b0}}, ring_thickness});
        fc_c  = coord_t'({{(COORD_W-FP_W){1'b0}}, footprint_cols});
        fr_c  = coord_t'({{(COORD_W-FP_W){1'b0}}, footprint_rows});
        fit   = (col_c >= rad) && (row_c >= rad) &&
                (col_c + rad < cols_eff) && (row_c + rad < rows_eff);

        i_lo_in  = '0;
        i_hi_in  = GC_C - coord_t'(1);
        j_lo_in  = '0;
        j_hi_in  = GR_C - coord_t'(1);
        empty_in = 1'b0;
        case (op_in)
            OP_CLEAR:
            begin
                empty_in = 1'b0;
            end
            OP_STAMP:
            begin
                i_lo_in  = col_c - rad;
                i_hi_in  = col_c + rad;
                j_lo_in  = row_c - rad;
                j_hi_in  = row_c + rad;
                empty_in = !fit;
            end
            OP_READ:
            begin
                i_lo_in = col_c;
                i_hi_in = col_c;
                j_lo_in = row_c;
                j_hi_in = row_c;
            end
            OP_CHECK:
            begin
                i_lo_in  = col_c - coord_t'(1);
                i_hi_in  = col_c + fc_c - coord_t'(2);
                j_lo_in  = row_c - coord_t'(1);
                j_hi_in  = row_c + fr_c - coord_t'(2);
                empty_in = (footprint_cols == '0) || (footprint_rows == '0);
            end
            default:
            begin
                empty_in = 1'b1;
            end
        endcase
    end

    assign in_grid = (i_reg >= coord_t'(0)) && (j_reg >= coord_t'(0)) &&
                     (i_reg < cols_eff) && (j_reg < rows_eff);
    assign acc     = cmd.step && ((op_reg == OP_CLEAR) || in_grid);
    assign inner   = (i_reg >= ii_lo_reg) && (i_reg <= ii_hi_reg) &&
                     (j_reg >= ji_lo_reg) && (j_reg <= ji_hi_reg);
    assign addr0   = {j_reg[RW-1:0], i_reg[CW-1:0]};

    assign status.empty = empty_reg;
    assign status.last  = (i_reg == i_hi_reg) && (j_reg == j_hi_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= op_in;
            i_lo_reg  <= i_lo_in;
            i_hi_reg  <= i_hi_in;
            j_hi_reg  <= j_hi_in;
            ii_lo_reg <= col_c - inr_c;
            ii_hi_reg <= col_c + inr_c;
            ji_lo_reg <= row_c - inr_c;
            ji_hi_reg <= row_c + inr_c;
            i_reg     <= i_lo_in;
            j_reg     <= j_lo_in;
            empty_reg <= empty_in;
            ia_reg    <= inner_amount;
            ra_reg    <= ring_amount;
            tol_reg   <= tolerance;
        end
        else if (cmd.step)
        begin
            if (i_reg == i_hi_reg)
            begin
                i_reg <= i_lo_reg;
                j_reg <= j_reg + coord_t'(1);
            end
            else
            begin
                i_reg <= i_reg + coord_t'(1);
            end
        end
        p_addr_reg <= addr0;
        p_amt_reg  <= inner ? ia_reg : ra_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg <= acc && (op_reg != OP_CLEAR);
        end
    end

    assign sum       = {rdata[CELL_W-1], rdata} +
                       {{(CELL_W+1-AMT_W){p_amt_reg[AMT_W-1]}}, p_amt_reg};
    assign sum_sat   = sum[CELL_W] ^ sum[CELL_W-1];
    assign sum_clamp = sum_sat ? (sum[CELL_W] ? CELL_MIN : CELL_MAX) : sum[CELL_W-1:0];

    always_comb
    begin
        if (op_reg == OP_CLEAR)
        begin
            ram_we    = acc;
            ram_waddr = addr0;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = p_valid_reg && (op_reg == OP_STAMP);
            ram_waddr = p_addr_reg;
            ram_wdata = sum_clamp;
        end
    end

    gisc_ram #(
        .WIDTH (CELL_W),
        .DEPTH (DEPTH)
    ) u_grid (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (addr0),
        .rdata (rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cell_reg    <= '0;
            allowed_reg <= (op_in == OP_CHECK);
            applied_reg <= (op_in == OP_STAMP) && fit;
            sat_reg     <= 1'b0;
        end
        else if (p_valid_reg)
        begin
            case (op_reg)
                OP_STAMP:
                begin
                    if (sum_sat)
                    begin
                        sat_reg <= 1'b1;
                    end
                end
                OP_READ:
                begin
                    cell_reg <= rdata;
                end
                OP_CHECK:
                begin
                    if ($signed(rdata) > $signed({1'b0, tol_reg}))
                    begin
                        allowed_reg <= 1'b0;
                    end
                end
                default:
                begin
                    cell_reg <= cell_reg;
                end
            endcase
        end
    end

    assign cell_threat   = cell_reg;
    assign allowed       = allowed_reg;
    assign stamp_applied = applied_reg;
    assign saturated     = sat_reg;

endmodule

// ----- sv/grid_influence_stamp_and_check_unit.sv -----
// top level of the grid influence stamp and check unit
// depends on gisc_pkg, gisc_ctrl, gisc_dp (which holds gisc_ram)
// done pulses after the start transfer once the N walked cells have drained, N being:
// clear GRID_COLS*GRID_ROWS, stamp (2r+1)^2 (0 if it does not fit), check footprint area, read 1; the next
// start is taken in the cycle after done. one grid cell per cycle through the ram.
// after reset a clear sweep of GRID_COLS*GRID_ROWS cells runs with busy high, no done.
module grid_influence_stamp_and_check_unit #(
    parameter int GRID_COLS = gisc_pkg::DEF_GRID_COLS,
    parameter int GRID_ROWS = gisc_pkg::DEF_GRID_ROWS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    output logic                               done,
    input  logic [1:0]                         op,
    input  logic [gisc_pkg::COL_W-1:0]         col,
    input  logic [gisc_pkg::COL_W-1:0]         row,
    input  logic [gisc_pkg::RAD_W-1:0]         inner_radius,
    input  logic [gisc_pkg::RAD_W-1:0]         ring_thickness,
    input  logic signed [gisc_pkg::AMT_W-1:0]  inner_amount,
    input  logic signed [gisc_pkg::AMT_W-1:0]  ring_amount,
    input  logic [gisc_pkg::FP_W-1:0]          footprint_cols,
    input  logic [gisc_pkg::FP_W-1:0]          footprint_rows,
    input  logic [gisc_pkg::TOL_W-1:0]         tolerance,
    output logic signed [gisc_pkg::CELL_W-1:0] cell_threat,
    output logic                               allowed,
    output logic                               stamp_applied,
    output logic                               saturated,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [gisc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gisc_pkg::EXT_W-1:0]         cfg_data
);

    import gisc_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    gisc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    gisc_dp #(
        .GRID_COLS (GRID_COLS),
        .GRID_ROWS (GRID_ROWS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .op             (op),
        .col            (col),
        .row            (row),
        .inner_radius   (inner_radius),
        .ring_thickness (ring_thickness),
        .inner_amount   (inner_amount),
        .ring_amount    (ring_amount),
        .footprint_cols (footprint_cols),
        .footprint_rows (footprint_rows),
        .tolerance      (tolerance),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .cell_threat    (cell_threat),
        .allowed        (allowed),
        .stamp_applied  (stamp_applied),
        .saturated      (saturated)
    );

endmodule
